// ===== hw/rtl/tmclip_pkg.sv =====
// ----------------------------------------------------------------------------
// tmclip_pkg
// Shared constants and types of the tile map velocity clip block.
// ----------------------------------------------------------------------------
package tmclip_pkg;

  // Map geometry: square map of MAP_SIDE x MAP_SIDE one-bit tiles.
  localparam int MAP_SIDE  = 64;
  localparam int IDX_W     = $clog2(MAP_SIDE);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;

  // Map size registers are 7 bits wide; the effective size saturates here.
  localparam logic [6:0] MAP_LIM = 7'(MAP_SIDE);

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_FRAME_TIME = 2'd2;
  localparam logic [1:0] CFG_HALF_SIZE  = 2'd3;

  // Input item kinds.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Depth of the queue between front and back (power of two).
  localparam int QDEPTH = 2;

  // Box corner arithmetic in signed Q.24 tiles.
  localparam int CW   = 37;        // corner width
  localparam int TI_W = CW - 24;   // signed tile index width after floor
  localparam int DX_W = 33;        // velocity times frame time

  typedef struct packed {
    logic [6:0]  map_width;
    logic [6:0]  map_height;
    logic [15:0] frame_time;
    logic [7:0]  half_size;
  } cfg_t;

  // Clamped tile range along one axis.
  typedef struct packed {
    logic             empty;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic             is_query;
    logic [IDX_W-1:0] wr_x;
    logic [IDX_W-1:0] wr_y;
    logic             wr_wall;
    range_t           xf;   // x range around moved x
    range_t           xp;   // x range around current x
    range_t           yf;   // y range around moved y
    range_t           yp;   // y range around current y
  } qent_t;

endpackage

// ===== hw/rtl/tmclip_ram.sv =====
// ----------------------------------------------------------------------------
// tmclip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmclip_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tmclip_queue.sv =====
// ----------------------------------------------------------------------------
// tmclip_queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module tmclip_queue
  import tmclip_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output qent_t pop_data_o,
  output logic  empty_o
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  qent_t            slot_q [QDEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CNT_W'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/tmclip_front.sv =====
// ----------------------------------------------------------------------------
// tmclip_front
// Accept items, predict the move and turn every query into clamped tile ranges.
// ----------------------------------------------------------------------------
module tmclip_front
  import tmclip_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [5:0]         tile_x_i,
  input  logic [5:0]         tile_y_i,
  input  logic               is_wall_i,
  input  logic signed [17:0] pos_x_i,
  input  logic signed [17:0] pos_y_i,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  cfg_t               cfg_i,
  input  logic               clear_busy_i,
  output logic               push_o,
  output qent_t              push_data_o,
  input  logic               full_i
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]             fst_q, fst_d;
  logic                   mode_q;
  logic [5:0]             tile_x_q, tile_y_q;
  logic                   wall_q;
  logic signed [17:0]     pos_x_q, pos_y_q;
  logic signed [15:0]     vel_x_q, vel_y_q;
  logic signed [DX_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [CW-1:0]   px_c, py_c, fx_c, fy_c;
  logic [6:0]             lim_w, lim_h;
  logic                   accept;

  // Floor both corners to tile indexes and clamp them to the map in use.
  function automatic range_t axis_range(input logic signed [CW-1:0] c,
                                        input logic [7:0] half,
                                        input logic [6:0] lim);
    logic signed [CW-1:0]   hq;
    logic signed [CW-1:0]   lo_c, hi_c;
    logic signed [TI_W-1:0] lo_t, hi_t, lim_m1;
    range_t                 r;
    hq     = $signed({{(CW - 24){1'b0}}, half, 16'h0000});
    lo_c   = c - hq;
    hi_c   = c + hq;
    lo_t   = lo_c[CW-1:24];
    hi_t   = hi_c[CW-1:24];
    lim_m1 = $signed({{(TI_W - 7){1'b0}}, lim}) - TI_W'(1);
    if (lo_t < 0) begin
      lo_t = '0;
    end
    if (hi_t > lim_m1) begin
      hi_t = lim_m1;
    end
    r.empty = (lo_t > hi_t);
    r.lo    = lo_t[IDX_W-1:0];
    r.hi    = hi_t[IDX_W-1:0];
    return r;
  endfunction

  assign in_ready_o = (fst_q == F_IDLE) && !clear_busy_i;
  assign accept     = in_valid_i && in_ready_o;

  assign lim_w = (cfg_i.map_width  > MAP_LIM) ? MAP_LIM : cfg_i.map_width;
  assign lim_h = (cfg_i.map_height > MAP_LIM) ? MAP_LIM : cfg_i.map_height;

  assign px_c = $signed({{(CW - 34){pos_x_q[17]}}, pos_x_q, 16'h0000});
  assign py_c = $signed({{(CW - 34){pos_y_q[17]}}, pos_y_q, 16'h0000});
  assign fx_c = px_c + $signed({{(CW - DX_W){dx_q[DX_W-1]}}, dx_q});
  assign fy_c = py_c + $signed({{(CW - DX_W){dy_q[DX_W-1]}}, dy_q});

  always_comb begin
    push_data_o.is_query = (mode_q == MODE_QUERY);
    push_data_o.wr_x     = tile_x_q;
    push_data_o.wr_y     = tile_y_q;
    push_data_o.wr_wall  = wall_q;
    push_data_o.xf       = axis_range(fx_c, cfg_i.half_size, lim_w);
    push_data_o.xp       = axis_range(px_c, cfg_i.half_size, lim_w);
    push_data_o.yf       = axis_range(fy_c, cfg_i.half_size, lim_h);
    push_data_o.yp       = axis_range(py_c, cfg_i.half_size, lim_h);
  end

  assign push_o = (fst_q == F_PUSH) && !full_i;

  always_comb begin
    fst_d = fst_q;
    dx_d  = dx_q;
    dy_d  = dy_q;
    unique case (fst_q)
      F_IDLE: begin
        if (accept) begin
          fst_d = (mode_i == MODE_QUERY) ? F_MUL : F_PUSH;
        end
      end
      F_MUL: begin
        dx_d  = DX_W'(vel_x_q) * DX_W'($signed({1'b0, cfg_i.frame_time}));
        dy_d  = DX_W'(vel_y_q) * DX_W'($signed({1'b0, cfg_i.frame_time}));
        fst_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          fst_d = F_IDLE;
        end
      end
      default: begin
        fst_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fst_q <= F_IDLE;
    end else begin
      fst_q <= fst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_i;
      tile_x_q <= tile_x_i;
      tile_y_q <= tile_y_i;
      wall_q   <= is_wall_i;
      pos_x_q  <= pos_x_i;
      pos_y_q  <= pos_y_i;
      vel_x_q  <= vel_x_i;
      vel_y_q  <= vel_y_i;
    end
    dx_q <= dx_d;
    dy_q <= dy_d;
  end

endmodule

// ===== hw/rtl/tmclip_back.sv =====
// ----------------------------------------------------------------------------
// tmclip_back
// Own the wall map: clear it after reset, apply tile writes, sweep query boxes.
// ----------------------------------------------------------------------------
module tmclip_back
  import tmclip_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  qent_t head_i,
  input  logic  empty_i,
  output logic  pop_o,
  output logic  clear_busy_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic  keep_x_o,
  output logic  keep_y_o
);

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_SWEEP = 2'd2;

  localparam logic [1:0] BOX_FULL  = 2'd0;
  localparam logic [1:0] BOX_XONLY = 2'd1;
  localparam logic [1:0] BOX_YONLY = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  qent_t             ent_q, ent_d;
  logic [1:0]        box_q, box_d;
  logic [IDX_W-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic              issue_q, issue_d;
  logic              chk_q, chk_d;
  logic              chk_last_q, chk_last_d;
  logic              out_valid_q, out_valid_d;
  logic              keep_x_q, keep_x_d, keep_y_q, keep_y_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_wdata;
  logic              ram_rdata;

  logic              start_box;
  qent_t             start_ent;
  range_t            xr, yr, xr_n, yr_n;
  logic              last_tile, hit, miss;

  function automatic range_t sel_x(input qent_t e, input logic [1:0] b);
    return (b == BOX_YONLY) ? e.xp : e.xf;
  endfunction

  function automatic range_t sel_y(input qent_t e, input logic [1:0] b);
    return (b == BOX_XONLY) ? e.yp : e.yf;
  endfunction

  tmclip_ram #(
    .WIDTH (1),
    .DEPTH (MAP_CELLS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i ({cy_q, cx_q}),
    .rdata_o (ram_rdata)
  );

  assign clear_busy_o = (state_q == B_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign keep_x_o     = keep_x_q;
  assign keep_y_o     = keep_y_q;

  assign xr        = sel_x(ent_q, box_q);
  assign yr        = sel_y(ent_q, box_q);
  assign last_tile = (cx_q == xr.hi) && (cy_q == yr.hi);
  assign hit       = chk_q && ram_rdata;
  assign miss      = (chk_q && !ram_rdata && chk_last_q) || (!chk_q && !issue_q);
  assign start_ent = (state_q == B_IDLE) ? head_i : ent_q;

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    ent_d       = ent_q;
    box_d       = box_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    issue_d     = issue_q;
    chk_d       = 1'b0;
    chk_last_d  = chk_last_q;
    out_valid_d = out_valid_q;
    keep_x_d    = keep_x_q;
    keep_y_d    = keep_y_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = {head_i.wr_y, head_i.wr_x};
    ram_wdata   = head_i.wr_wall;
    start_box   = 1'b0;
    xr_n        = '0;
    yr_n        = '0;

    // Drop the result once the consumer takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      B_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = 1'b0;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(MAP_CELLS - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          if (!head_i.is_query) begin
            ram_we = 1'b1;
            pop_o  = 1'b1;
          end else if (!out_valid_q || out_ready_i) begin
            pop_o     = 1'b1;
            ent_d     = head_i;
            box_d     = BOX_FULL;
            start_box = 1'b1;
            state_d   = B_SWEEP;
          end
        end
      end
      B_SWEEP: begin
        // Issue one tile read per cycle, row by row.
        if (issue_q) begin
          chk_d      = 1'b1;
          chk_last_d = last_tile;
          issue_d    = !last_tile;
          if (cx_q == xr.hi) begin
            cx_d = xr.lo;
            cy_d = cy_q + IDX_W'(1);
          end else begin
            cx_d = cx_q + IDX_W'(1);
          end
        end
        if (hit || miss) begin
          issue_d = 1'b0;
          chk_d   = 1'b0;
          unique case (box_q)
            BOX_FULL: begin
              if (hit) begin
                box_d     = BOX_XONLY;
                start_box = 1'b1;
              end else begin
                state_d     = B_IDLE;
                out_valid_d = 1'b1;
                keep_x_d    = 1'b1;
                keep_y_d    = 1'b1;
              end
            end
            BOX_XONLY: begin
              if (hit) begin
                box_d     = BOX_YONLY;
                start_box = 1'b1;
              end else begin
                state_d     = B_IDLE;
                out_valid_d = 1'b1;
                keep_x_d    = 1'b1;
                keep_y_d    = 1'b0;
              end
            end
            BOX_YONLY: begin
              state_d     = B_IDLE;
              out_valid_d = 1'b1;
              keep_x_d    = 1'b0;
              keep_y_d    = !hit;
            end
            default: begin
              state_d = B_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase

    // Load the first tile of the next box; an empty box misses at once.
    if (start_box) begin
      xr_n    = sel_x(start_ent, box_d);
      yr_n    = sel_y(start_ent, box_d);
      cx_d    = xr_n.lo;
      cy_d    = yr_n.lo;
      issue_d = !(xr_n.empty || yr_n.empty);
      chk_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_addr_q  <= '0;
      box_q       <= BOX_FULL;
      issue_q     <= 1'b0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      box_q       <= box_d;
      issue_q     <= issue_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q      <= ent_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    chk_last_q <= chk_last_d;
    keep_x_q   <= keep_x_d;
    keep_y_q   <= keep_y_d;
  end

endmodule

// ===== hw/rtl/tile_map_aabb_velocity_clip_top.sv =====
// ----------------------------------------------------------------------------
// tile_map_aabb_velocity_clip_top
// Tile map collision: clip entity velocity axes against a one-bit wall map.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   -------  ---------  ----------------------  ------------------------------
//   in       input      in_valid_i/in_ready_o   mode, tile_x/y, is_wall,
//                                               pos_x/y, vel_x/y
//   out      output     out_valid_o/out_ready_i keep_x, keep_y (queries only)
//   cfg      input      cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// Steps: the front takes a tile write through accept and push, and a query
//   through accept, multiply velocity by frame time, classify into tile ranges.
//   The back applies a write at the queue head directly, and for a query
//   dispatches it, then for each box swept issues one tile read per cycle up to
//   the first wall (a box wholly off the map misses without a read); the single
//   read port of the map memory sets this.
// Reset: the back first clears the whole map, one tile a cycle;
//   in_ready_o stays low meanwhile. Configuration writes are taken throughout.
// Stalls: a two-entry queue parts front and back. A finished result waits in
//   the output register while the back keeps applying tile writes.
//
module tile_map_aabb_velocity_clip_top
  import tmclip_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  // Item channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [5:0]         tile_x_i,
  input  logic [5:0]         tile_y_i,
  input  logic               is_wall_i,
  input  logic signed [17:0] pos_x_i,
  input  logic signed [17:0] pos_y_i,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,

  // Result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               keep_x_o,
  output logic               keep_y_o,

  // Configuration write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);

  cfg_t  cfg_q, cfg_d;
  logic  push;
  qent_t push_data;
  logic  full;
  logic  pop;
  qent_t head;
  logic  empty;
  logic  clear_busy;

  // Configuration registers: write only, taken at once.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAP_WIDTH:  cfg_d.map_width  = cfg_data_i[6:0];
        CFG_MAP_HEIGHT: cfg_d.map_height = cfg_data_i[6:0];
        CFG_FRAME_TIME: cfg_d.frame_time = cfg_data_i;
        CFG_HALF_SIZE:  cfg_d.half_size  = cfg_data_i[7:0];
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_width  <= 7'd64;
      cfg_q.map_height <= 7'd64;
      cfg_q.frame_time <= 16'd1092;
      cfg_q.half_size  <= 8'd102;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept a transaction and classify it.
  tmclip_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .tile_x_i     (tile_x_i),
    .tile_y_i     (tile_y_i),
    .is_wall_i    (is_wall_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .vel_x_i      (vel_x_i),
    .vel_y_i      (vel_y_i),
    .cfg_i        (cfg_q),
    .clear_busy_i (clear_busy),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  // Hold classified items until the back is free.
  tmclip_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head),
    .empty_o     (empty)
  );

  // Back: apply writes to the map and sweep query boxes.
  tmclip_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .clear_busy_o (clear_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .keep_x_o     (keep_x_o),
    .keep_y_o     (keep_y_o)
  );

endmodule

// ===== tb/tile_map_aabb_velocity_clip_top_tb.sv =====
// ----------------------------------------------------------------------------
// tile_map_aabb_velocity_clip_top_tb
// Self-checking bench for the tile map velocity clip block: it mirrors the
// wall map and registers, predicts keep_x/keep_y for every query accepted and
// compares each result transaction in order, under random idling and stalls.
// ----------------------------------------------------------------------------
module tile_map_aabb_velocity_clip_top_tb;
  import tmclip_pkg::*;

  // Cycles without any transaction before the run is declared hung.
  localparam int HANG_LIMIT   = 20000;
  // Cycles allowed for queued tile writes to retire once results are in.
  localparam int DRAIN_CYCLES = 64;
  // Length of the long output hold-off.
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    logic               mode;
    logic [5:0]         tile_x;
    logic [5:0]         tile_y;
    logic               is_wall;
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } map_item_t;

  typedef struct {
    logic keep_x;
    logic keep_y;
  } clip_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               mode_i;
  logic [5:0]         tile_x_i;
  logic [5:0]         tile_y_i;
  logic               is_wall_i;
  logic signed [17:0] pos_x_i;
  logic signed [17:0] pos_y_i;
  logic signed [15:0] vel_x_i;
  logic signed [15:0] vel_y_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               keep_x_o;
  logic               keep_y_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [15:0]        cfg_data_i;

  // Shadow of the block state: wall bits and the four registers.
  bit         wall_shadow [MAP_CELLS];
  logic [6:0]  cfg_width  = 7'd64;
  logic [6:0]  cfg_height = 7'd64;
  logic [15:0] cfg_frame  = 16'd1092;
  logic [7:0]  cfg_half   = 8'd102;

  // Clip results predicted for accepted queries, oldest first.
  clip_t pending_clips [$];

  int error_count  = 0;
  int result_count = 0;
  int in_idle_pct  = 0;
  int out_stall_pct = 0;
  int hold_len     = 0;
  int quiet_cycles = 0;

  tile_map_aabb_velocity_clip_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .tile_x_i    (tile_x_i),
    .tile_y_i    (tile_y_i),
    .is_wall_i   (is_wall_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .keep_x_o    (keep_x_o),
    .keep_y_o    (keep_y_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Sweep a square box centred at (cx, cy), both signed Q.24 tiles, over the
  // wall shadow. Tiles left of or above the map, or past the effective size,
  // count as open; the arithmetic shift floors toward minus infinity.
  function automatic bit box_blocked(longint cx, longint cy);
    longint half, w, h, x0, x1, y0, y1, x, y;
    half = longint'(cfg_half) * 65536;
    w = (cfg_width  > MAP_SIDE) ? longint'(MAP_SIDE) : longint'(cfg_width);
    h = (cfg_height > MAP_SIDE) ? longint'(MAP_SIDE) : longint'(cfg_height);
    x0 = (cx - half) >>> 24;
    x1 = (cx + half) >>> 24;
    y0 = (cy - half) >>> 24;
    y1 = (cy + half) >>> 24;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > w - 1) x1 = w - 1;
    if (y1 > h - 1) y1 = h - 1;
    for (y = y0; y <= y1; y++) begin
      for (x = x0; x <= x1; x++) begin
        if (wall_shadow[y * MAP_SIDE + x]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Full move first; on a hit the x-only move decides, then the y-only move.
  function automatic clip_t predict_clip(map_item_t it);
    longint px, py, fx, fy;
    clip_t  r;
    px = longint'(it.pos_x) * 65536;
    py = longint'(it.pos_y) * 65536;
    fx = px + longint'(it.vel_x) * longint'(cfg_frame);
    fy = py + longint'(it.vel_y) * longint'(cfg_frame);
    r.keep_x = 1'b1;
    r.keep_y = 1'b1;
    if (box_blocked(fx, fy)) begin
      if (!box_blocked(fx, py)) begin
        r.keep_y = 1'b0;
      end else if (!box_blocked(px, fy)) begin
        r.keep_x = 1'b0;
      end else begin
        r.keep_x = 1'b0;
        r.keep_y = 1'b0;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------

  // Fields that an item kind ignores are filled at random to toggle them.
  function automatic map_item_t make_write(int tx, int ty, bit wall);
    map_item_t it;
    it.mode    = MODE_WRITE;
    it.tile_x  = tx[5:0];
    it.tile_y  = ty[5:0];
    it.is_wall = wall;
    it.pos_x   = 18'($urandom);
    it.pos_y   = 18'($urandom);
    it.vel_x   = 16'($urandom);
    it.vel_y   = 16'($urandom);
    return it;
  endfunction

  // Positions in Q10.8 tiles, velocities in Q8.8 tiles per second.
  function automatic map_item_t make_query(int px, int py, int vx, int vy);
    map_item_t it;
    it.mode    = MODE_QUERY;
    it.tile_x  = 6'($urandom);
    it.tile_y  = 6'($urandom);
    it.is_wall = 1'($urandom);
    it.pos_x   = px[17:0];
    it.pos_y   = py[17:0];
    it.vel_x   = vx[15:0];
    it.vel_y   = vy[15:0];
    return it;
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_tile(int t);
    return (t < 0) ? 0 : (t > MAP_SIDE - 1) ? MAP_SIDE - 1 : t;
  endfunction

  // Mostly moves of a few tiles per frame, sometimes the full field range.
  function automatic int random_velocity();
    if ($urandom_range(99) < 75) return rand_between(-25000, 25000);
    return rand_between(-32768, 32767);
  endfunction

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------

  // Offer one item after a random idle gap and hold it until the transaction
  // completes; then mirror its effect in the shadow state.
  task automatic send_item(map_item_t it);
    int gap;
    gap = 0;
    while (gap < 64 && $urandom_range(99) < in_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= it.mode;
    tile_x_i   <= it.tile_x;
    tile_y_i   <= it.tile_y;
    is_wall_i  <= it.is_wall;
    pos_x_i    <= it.pos_x;
    pos_y_i    <= it.pos_y;
    vel_x_i    <= it.vel_x;
    vel_y_i    <= it.vel_y;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (it.mode == MODE_QUERY) begin
      pending_clips.push_back(predict_clip(it));
    end else begin
      wall_shadow[int'(it.tile_y) * MAP_SIDE + int'(it.tile_x)] = it.is_wall;
    end
  endtask

  // Drop valid, wait for every predicted result, then let queued tile writes
  // retire so the block is idle.
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_clips.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAP_WIDTH:  cfg_width  = data[6:0];
      CFG_MAP_HEIGHT: cfg_height = data[6:0];
      CFG_FRAME_TIME: cfg_frame  = data;
      CFG_HALF_SIZE:  cfg_half   = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(int w, int h, int ft, int hs);
    settle_block();
    write_reg(CFG_MAP_WIDTH,  16'(w));
    write_reg(CFG_MAP_HEIGHT, 16'(h));
    write_reg(CFG_FRAME_TIME, 16'(ft));
    write_reg(CFG_HALF_SIZE,  16'(hs));
  endtask

  // Random traffic: mostly a few walls placed around a spot in or just off
  // the map followed by queries near that spot; the rest is raw noise.
  task automatic run_traffic(int n_items);
    int sent, span_x, span_y, cx, cy;
    map_item_t it;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        span_x = (cfg_width  > MAP_SIDE) ? MAP_SIDE : int'(cfg_width);
        span_y = (cfg_height > MAP_SIDE) ? MAP_SIDE : int'(cfg_height);
        cx = rand_between(-2, span_x + 1);
        cy = rand_between(-2, span_y + 1);
        repeat ($urandom_range(3)) begin
          send_item(make_write(clamp_tile(cx + rand_between(-2, 2)),
                               clamp_tile(cy + rand_between(-2, 2)),
                               $urandom_range(99) < 80));
          sent++;
        end
        repeat (1 + $urandom_range(1)) begin
          send_item(make_query(cx * 256 + rand_between(-128, 383),
                               cy * 256 + rand_between(-128, 383),
                               random_velocity(), random_velocity()));
          sent++;
        end
      end else begin
        it.mode    = 1'($urandom);
        it.tile_x  = 6'($urandom);
        it.tile_y  = 6'($urandom);
        it.is_wall = 1'($urandom);
        it.pos_x   = 18'($urandom);
        it.pos_y   = 18'($urandom);
        it.vel_x   = 16'($urandom);
        it.vel_y   = 16'($urandom);
        send_item(it);
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    error_count++;
    $display("mismatch at result %0d: %s", result_count, msg);
  endtask

  // Compare every result transaction with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    clip_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count++;
      if (pending_clips.size() == 0) begin
        report_mismatch("result with no query waiting");
      end else begin
        want = pending_clips.pop_front();
        if (keep_x_o !== want.keep_x)
          report_mismatch($sformatf("keep_x got %b want %b", keep_x_o, want.keep_x));
        if (keep_y_o !== want.keep_y)
          report_mismatch($sformatf("keep_y got %b want %b", keep_y_o, want.keep_y));
      end
    end
  end

  // Result side: stall at the current rate, or hold off for a counted stretch
  // when a test asks for one.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_len - 1) @(negedge clk_i);
        hold_len = 0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Hang detection: count cycles in which neither channel moves anything.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", HANG_LIMIT);
        $display("[tile_map_aabb_velocity_clip_top] ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: open map, each clip outcome, boxes leaving the map on
  // either side, field extremes, and clearing a wall again.
  task automatic test_open_and_blocked_moves();
    send_item(make_query(5 * 256 + 128, 5 * 256 + 128, 0, 0));
    send_item(make_write(10, 10, 1'b1));
    send_item(make_write(10, 8, 1'b1));
    send_item(make_write(11, 10, 1'b1));
    // diagonal into the corner walls: both axes blocked
    send_item(make_query(11 * 256 + 128, 8 * 256 + 128, -23000, 23000));
    // straight up into a wall: only y clipped
    send_item(make_query(10 * 256 + 128, 11 * 256 + 128, 0, -23000));
    // straight left into a wall: only x clipped
    send_item(make_query(12 * 256 + 128, 10 * 256 + 128, -23000, 0));
    // box wholly above and left of the map
    send_item(make_query(-51, -51, -23000, -23000));
    send_item(make_write(0, 0, 1'b1));
    send_item(make_query(26, 26, -23000, 0));
    send_item(make_write(63, 63, 1'b1));
    send_item(make_query(63 * 256 + 128, 63 * 256 + 128, 23000, 23000));
    send_item(make_query(63 * 256 + 128, 63 * 256 + 128, 0, 0));
    send_item(make_query(131071, -131072, 32767, -32768));
    send_item(make_query(-131072, 131071, -32768, 32767));
    send_item(make_write(10, 10, 1'b0));
    send_item(make_query(11 * 256 + 128, 8 * 256 + 128, -23000, 23000));
  endtask

  // Zero map size hides every wall, oversized registers act as the full
  // map, and a wall stored past the used width shows once the width grows.
  task automatic test_map_extent_registers();
    apply_config(0, 0, 1092, 102);
    send_item(make_query(63 * 256 + 128, 63 * 256 + 128, 0, 0));
    apply_config(127, 127, 1092, 102);
    send_item(make_query(63 * 256 + 128, 63 * 256 + 128, 0, 0));
    apply_config(8, 8, 1092, 102);
    send_item(make_write(20, 5, 1'b1));
    send_item(make_query(20 * 256 + 128, 5 * 256 + 128, 0, 0));
    apply_config(64, 64, 1092, 102);
    send_item(make_query(20 * 256 + 128, 5 * 256 + 128, 0, 0));
  endtask

  // Zero half size covers only the centre tile; zero frame time freezes the
  // move; the largest half size and frame time stretch both.
  task automatic test_box_size_and_frame_time();
    apply_config(64, 64, 0, 0);
    send_item(make_query(11 * 256, 10 * 256, 32767, 32767));
    send_item(make_query(11 * 256 - 1, 10 * 256 + 128, -32768, 0));
    apply_config(64, 64, 65535, 255);
    send_item(make_query(12 * 256 + 128, 12 * 256 + 128, 256, 0));
    send_item(make_query(8 * 256 + 128, 9 * 256 + 128, 512, -512));
    send_item(make_query(20 * 256, 4 * 256, 32767, -32768));
  endtask

  // Random traffic over each idling pattern, each with its own settings.
  task automatic test_random_traffic();
    apply_config(64, 64, 1092, 102);
    in_idle_pct = 0;  out_stall_pct = 0;
    run_traffic(90);
    apply_config(127, 100, 2000, 180);
    in_idle_pct = 86; out_stall_pct = 0;
    run_traffic(90);
    apply_config(16, 1, 3000, 60);
    in_idle_pct = 0;  out_stall_pct = 86;
    run_traffic(90);
    apply_config($urandom_range(1, 64), $urandom_range(1, 64),
                 $urandom_range(65535), $urandom_range(255));
    in_idle_pct = 37; out_stall_pct = 37;
    run_traffic(90);
  endtask

  // Hold the result side off while items keep coming, so the internal queue
  // and output register fill and the input stalls.
  task automatic test_full_output_stall();
    apply_config(64, 64, 1092, 102);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_len      = HOLD_CYCLES;
    run_traffic(20);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    mode_i     = MODE_WRITE;
    tile_x_i   = '0;
    tile_y_i   = '0;
    is_wall_i  = 1'b0;
    pos_x_i    = '0;
    pos_y_i    = '0;
    vel_x_i    = '0;
    vel_y_i    = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_MAP_WIDTH;
    cfg_data_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // The block clears its map before taking items; the handshake waits.
    test_open_and_blocked_moves();
    test_map_extent_registers();
    test_box_size_and_frame_time();
    test_random_traffic();
    test_full_output_stall();

    settle_block();
    if (error_count == 0) begin
      $display("[tile_map_aabb_velocity_clip_top] OK");
    end else begin
      $display("[tile_map_aabb_velocity_clip_top] ERROR");
    end
    $finish;
  end

endmodule
